@@ sv/dmm_pkg.sv @@
`default_nettype none
package dmm_pkg;

  // Matrix store geometry
  localparam int unsigned MaxDim   = 8;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned AddrW    = 2 * IdxW;
  localparam int unsigned ElemW    = 16;
  localparam int unsigned ProdW    = 2 * ElemW;
  localparam int unsigned SumW     = 35;
  localparam int unsigned DimW     = 4;
  localparam int unsigned OpW      = 2;
  localparam int unsigned CfgIdxW  = 2;

  // Operation codes
  localparam logic [OpW-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OpW-1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [DimW-1:0] DIM_RESET = 4'd8;

  // Clamp a dimension register to 1..MaxDim and return the last index
  function automatic logic [IdxW-1:0] last_index(input logic [DimW-1:0] dim);
    logic [IdxW-1:0] r;
    if (dim == '0) begin
      r = '0;
    end else if (dim >= DimW'(MaxDim)) begin
      r = IdxW'(MaxDim - 1);
    end else begin
      r = IdxW'(dim - 4'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/dmm_if.sv @@
`default_nettype none
// Input channel: element writes and compute commands
interface dmm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [dmm_pkg::OpW-1:0]               operation;
  logic [dmm_pkg::IdxW-1:0]              row_index;
  logic [dmm_pkg::IdxW-1:0]              col_index;
  logic signed [dmm_pkg::ElemW-1:0]      element_value;

  modport source (output valid, operation, row_index, col_index, element_value,
                  input ready);
  modport sink (input valid, operation, row_index, col_index, element_value,
                output ready);
endinterface

// Output channel: result elements
interface dmm_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [dmm_pkg::IdxW-1:0]              out_row;
  logic [dmm_pkg::IdxW-1:0]              out_col;
  logic signed [dmm_pkg::SumW-1:0]       product_sum;
  logic                                  last_element;

  modport source (output valid, out_row, out_col, product_sum, last_element,
                  input ready);
  modport sink (input valid, out_row, out_col, product_sum, last_element,
                output ready);
endinterface
`default_nettype wire

@@ sv/dense_matrix_multiply.sv @@
`default_nettype none
// Dense matrix multiply C = A x B on signed Q8.8 elements, results in exact
// Q19.16. A and B sit in two 64x16 synchronous RAMs addressed {row, col}.
// A write transaction is operation 0 for A or 1 for B, stored when it is
// accepted; operation 3 is dropped. A compute transaction emits rows_a x cols_b
// results in row-major order, the final one flagged by last_element. Each
// result is built at one multiply-accumulate per cycle, limited by the single
// read port of each RAM, then passes the read, multiply, accumulate and emit
// steps before the next result starts; the emit may stall on out_if.ready.
// Input is held off while a compute runs; the final result may still wait in
// the output register while new transactions are taken. Dimensions are
// sampled when the compute transaction is accepted; zero reads as 1 and values
// above 8 read as 8. Reading an element that was never written returns an undefined value.
module dense_matrix_multiply (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dmm_in_if.sink                             in_if,
  dmm_out_if.source                          out_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [dmm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dmm_pkg::DimW-1:0]      cfg_data_i
);
  import dmm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [DimW-1:0]         rows_a_q, inner_dim_q, cols_b_q;
  logic [IdxW-1:0]         i_last_q, k_last_q, j_last_q;
  logic [IdxW-1:0]         i_q, j_q, k_q;
  logic [IdxW-1:0]         i_d, j_d, k_d;

  logic [ElemW-1:0]        mem_a [MaxDim*MaxDim];
  logic [ElemW-1:0]        mem_b [MaxDim*MaxDim];
  logic [ElemW-1:0]        a_rd_q, b_rd_q;

  logic                    s1_valid_q, s1_last_q;
  logic                    s2_valid_q, s2_last_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [SumW-1:0]  acc_q;
  logic                    done_q;

  logic                    out_valid_q;
  logic [IdxW-1:0]         out_row_q, out_col_q;
  logic signed [SumW-1:0]  out_sum_q;
  logic                    out_last_q;

  logic                    in_fire, wr_a, wr_b, start;
  logic                    issue, emit, last_elem;
  logic [AddrW-1:0]        wr_addr, rd_addr_a, rd_addr_b;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign wr_a        = in_fire && (in_if.operation == OP_WRITE_A);
  assign wr_b        = in_fire && (in_if.operation == OP_WRITE_B);
  assign start       = in_fire && (in_if.operation == OP_COMPUTE);
  assign wr_addr     = {in_if.row_index, in_if.col_index};

  assign issue       = (state_q == ST_RUN);
  assign rd_addr_a   = {i_q, k_q};
  assign rd_addr_b   = {k_q, j_q};

  assign last_elem   = (i_q == i_last_q) && (j_q == j_last_q);
  assign emit        = (state_q == ST_EMIT) && (!out_valid_q || out_if.ready);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Matrix stores: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_if.element_value;
    end
    a_rd_q <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_if.element_value;
    end
    b_rd_q <= mem_b[rd_addr_b];
  end

  // Sequencer over (i, j, k)
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (k_q == k_last_q) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (done_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          if (last_elem) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RUN;
            if (j_q == j_last_q) begin
              j_d = '0;
              i_d = i_q + 3'd1;
            end else begin
              j_d = j_q + 3'd1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // Dimensions latched at compute start
  always_ff @(posedge clk_i) begin
    if (start) begin
      i_last_q <= last_index(rows_a_q);
      k_last_q <= last_index(inner_dim_q);
      j_last_q <= last_index(cols_b_q);
    end
  end

  // MAC pipeline control: read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s1_last_q  <= issue && (k_q == k_last_q);
      s2_valid_q <= s1_valid_q;
      s2_last_q  <= s1_last_q;
      done_q     <= s2_valid_q && s2_last_q;
    end
  end

  // Product and running sum
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(a_rd_q) * $signed(b_rd_q);
    if (start || emit) begin
      acc_q <= '0;
    end else if (s2_valid_q) begin
      acc_q <= acc_q + SumW'(prod_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q  <= i_q;
      out_col_q  <= j_q;
      out_sum_q  <= acc_q;
      out_last_q <= last_elem;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.out_row      = out_row_q;
  assign out_if.out_col      = out_col_q;
  assign out_if.product_sum  = out_sum_q;
  assign out_if.last_element = out_last_q;

  // Checks
  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_DRAIN))
    else $error("accumulation finished outside drain");

  a_no_input_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q || s2_valid_q) |-> !in_if.ready)
    else $error("input taken while MAC pipeline busy");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result presented without emit");

endmodule
`default_nettype wire
